FILE: sv/adh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adh_pkg
// Types, phase codes and register indexes shared by the drag and heating step.
// ----------------------------------------------------------------------------
package adh_pkg;

    typedef struct packed {
        logic signed [63:0] vel_x;
        logic signed [63:0] vel_y;
        logic signed [63:0] vel_z;
        logic signed [31:0] density;
    } t_in;

    typedef struct packed {
        logic signed [63:0] new_vel_x;
        logic signed [63:0] new_vel_y;
        logic signed [63:0] new_vel_z;
        logic signed [31:0] drag_accel;
        logic signed [31:0] heating_rate;
        logic signed [31:0] heat_total;
        logic               status;
    } t_out;

    typedef struct packed {
        logic signed [31:0] mass;
        logic signed [31:0] drag_area;
        logic signed [31:0] heat_coefficient;
        logic               heat_cap_enable;
        logic signed [31:0] heat_limit;
    } t_cfg;

    localparam logic [2:0] REG_MASS       = 3'd0;
    localparam logic [2:0] REG_DRAG_AREA  = 3'd1;
    localparam logic [2:0] REG_HEAT_COEFF = 3'd2;
    localparam logic [2:0] REG_CAP_EN     = 3'd3;
    localparam logic [2:0] REG_HEAT_LIMIT = 3'd4;

    localparam logic signed [31:0] MASS_RESET  = 32'sd65536;
    localparam logic signed [31:0] LIMIT_RESET = 32'sd65536;

    typedef enum logic [4:0] {
        PH_SQ0, PH_SQ1, PH_SQ2, PH_SQRT, PH_V2, PH_V3, PH_DDA, PH_DIVM,
        PH_DRAG, PH_DHC, PH_HEAT, PH_P0, PH_DV0, PH_P1, PH_DV1, PH_P2, PH_DV2
    } t_phase;

    // Last count value of each phase kind.
    localparam logic [6:0] LAST_MUL  = 7'd4;
    localparam logic [6:0] LAST_SQRT = 7'd32;
    localparam logic [6:0] LAST_DIVM = 7'd65;
    localparam logic [6:0] LAST_DV   = 7'd33;

    typedef struct packed {
        logic       load_in;
        logic       commit;
        t_phase     ph;
        logic [6:0] cnt;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic speed_zero;
    } t_stat;

    function automatic logic ph_is_mul(t_phase p);
        logic m;
        case (p)
            PH_SQRT, PH_DIVM, PH_DV0, PH_DV1, PH_DV2: m = 1'b0;
            default: m = 1'b1;
        endcase
        return m;
    endfunction

    function automatic logic [6:0] ph_last(t_phase p);
        logic [6:0] l;
        case (p)
            PH_SQRT:                l = LAST_SQRT;
            PH_DIVM:                l = LAST_DIVM;
            PH_DV0, PH_DV1, PH_DV2: l = LAST_DV;
            default:                l = LAST_MUL;
        endcase
        return l;
    endfunction

endpackage

FILE: sv/aero_drag_heating_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aero_drag_heating_step
// Drag and heating update of one vehicle velocity per beat, APB register port.
// ----------------------------------------------------------------------------
// One item is in work at a time. An item with an invalid configuration or a
// nonpositive density goes from the check state straight to the commit. Any
// other item runs a check, twelve products on one shared 32x32 multiplier, a
// bit pair square root, a division by mass and three divisions by speed, one
// quotient bit per cycle plus a load and a store step each, and a commit; when
// the speed is zero it ends after the square root. The finished result waits
// in an output register; the commit stalls only while the previous result is
// still untaken, and a new beat is accepted in the cycle after the commit.
module aero_drag_heating_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  adh_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output adh_pkg::t_out o_out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import adh_pkg::*;

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;
    logic  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mass             <= MASS_RESET;
            r_cfg.drag_area        <= '0;
            r_cfg.heat_coefficient <= '0;
            r_cfg.heat_cap_enable  <= 1'b0;
            r_cfg.heat_limit       <= LIMIT_RESET;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_MASS:       r_cfg.mass             <= pwdata;
                REG_DRAG_AREA:  r_cfg.drag_area        <= pwdata;
                REG_HEAT_COEFF: r_cfg.heat_coefficient <= pwdata;
                REG_CAP_EN:     r_cfg.heat_cap_enable  <= pwdata[0];
                REG_HEAT_LIMIT: r_cfg.heat_limit       <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_MASS:       prdata = r_cfg.mass;
            REG_DRAG_AREA:  prdata = r_cfg.drag_area;
            REG_HEAT_COEFF: prdata = r_cfg.heat_coefficient;
            REG_CAP_EN:     prdata = {31'd0, r_cfg.heat_cap_enable};
            REG_HEAT_LIMIT: prdata = r_cfg.heat_limit;
            default:        prdata = '0;
        endcase
    end

    adh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    adh_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg      (r_cfg),
        .i_in_data  (i_in_data),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );
endmodule

FILE: sv/adh_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adh_mul
// 64x64 to 128-bit unsigned multiplier, one 32x32 partial product per cycle while enabled.
// ----------------------------------------------------------------------------
module adh_mul (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [1:0]   i_step,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic [127:0] o_acc
);
    logic [127:0] r_acc;
    logic [127:0] n_acc;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    always_comb begin
        a_half = i_step[1] ? i_a[63:32] : i_a[31:0];
        b_half = i_step[0] ? i_b[63:32] : i_b[31:0];
        pp     = {32'd0, a_half} * {32'd0, b_half};
        case (i_step)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
        // The first step starts a fresh product.
        n_acc = ((i_step == 2'd0) ? 128'd0 : r_acc) + pp_sh;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;
endmodule

FILE: sv/adh_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adh_dp
// Datapath: input latch, squares, square root, divisions, state and result.
// ----------------------------------------------------------------------------
module adh_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  adh_pkg::t_cmd i_cmd,
    input  adh_pkg::t_cfg i_cfg,
    input  adh_pkg::t_in  i_in_data,
    output adh_pkg::t_stat o_stat,
    output adh_pkg::t_out o_out_data
);
    import adh_pkg::*;

    logic signed [63:0] r_vel [3];
    logic [47:0]        r_mag [3];
    logic               r_neg [3];
    logic [31:0]        r_dens;
    logic [63:0]        r_sum;
    logic [63:0]        r_x;
    logic [63:0]        r_root;
    logic [63:0]        r_bit;
    logic [63:0]        r_v2;
    logic [63:0]        r_v3;
    logic [63:0]        r_dc;
    logic [63:0]        r_drag;
    logic [63:0]        r_hc;
    logic [63:0]        r_heat_rate;
    logic [31:0]        r_rem;
    logic [63:0]        r_dvd;
    logic [63:0]        r_quo;
    logic               r_ovf;
    logic signed [31:0] r_heat;
    logic signed [31:0] r_last_drag;
    logic signed [31:0] r_last_heat;
    t_out               r_out;

    logic [63:0]        in_vel [3];
    logic [47:0]        ip [3];
    logic [127:0]       acc;
    logic [63:0]        acc_sat;
    logic [63:0]        mul_a;
    logic [63:0]        mul_b;
    logic               mul_en;
    logic               is_mul;
    logic               take;
    logic [1:0]         ax;
    logic [64:0]        sum_n;
    logic [63:0]        rb;
    logic [31:0]        den;
    logic [32:0]        trial;
    logic               ge;
    logic [32:0]        trial_sub;
    logic [31:0]        q;
    logic signed [31:0] dv;
    logic [64:0]        diff;
    logic [63:0]        vel_sub;
    logic               cfg_ok;
    logic               dens_pos;
    logic               normal;
    logic signed [31:0] n_last_drag;
    logic signed [31:0] n_last_heat;
    logic signed [31:0] n_heat;
    logic signed [32:0] hsum;
    logic signed [31:0] hsat;

    assign in_vel[0] = i_in_data.vel_x;
    assign in_vel[1] = i_in_data.vel_y;
    assign in_vel[2] = i_in_data.vel_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ip[k] = in_vel[k][63:16];
        end
    end

    always_comb begin
        case (i_cmd.ph)
            PH_SQ1, PH_P1, PH_DV1: ax = 2'd1;
            PH_SQ2, PH_P2, PH_DV2: ax = 2'd2;
            default:               ax = 2'd0;
        endcase
    end

    always_comb begin
        case (i_cmd.ph)
            PH_SQ0, PH_SQ1, PH_SQ2: begin
                mul_a = {16'd0, r_mag[ax]};
                mul_b = {16'd0, r_mag[ax]};
            end
            PH_V2: begin
                mul_a = r_root;
                mul_b = r_root;
            end
            PH_V3: begin
                mul_a = r_v2;
                mul_b = r_root;
            end
            PH_DDA: begin
                mul_a = {32'd0, r_dens};
                mul_b = {32'd0, i_cfg.drag_area};
            end
            PH_DRAG: begin
                mul_a = r_dc;
                mul_b = r_v2;
            end
            PH_DHC: begin
                mul_a = {32'd0, r_dens};
                mul_b = {32'd0, i_cfg.heat_coefficient};
            end
            PH_HEAT: begin
                mul_a = r_hc;
                mul_b = r_v3;
            end
            default: begin
                mul_a = {16'd0, r_mag[ax]};
                mul_b = r_drag;
            end
        endcase
    end

    assign is_mul  = ph_is_mul(i_cmd.ph);
    assign mul_en  = is_mul && (i_cmd.cnt[6:2] == 5'd0);
    assign take    = is_mul && (i_cmd.cnt == LAST_MUL);
    assign acc_sat = (acc[127:64] != 64'd0) ? {64{1'b1}} : acc[63:0];

    adh_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_step (i_cmd.cnt[1:0]),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_acc  (acc)
    );

    // Saturating accumulation of the squares and one square root step.
    assign sum_n = {1'b0, r_sum} + {1'b0, acc_sat};
    assign rb    = r_root + r_bit;

    // Restoring divider: one quotient bit a cycle.
    assign den       = (i_cmd.ph == PH_DIVM) ? i_cfg.mass : r_root[31:0];
    assign trial     = {r_rem, r_dvd[63]};
    assign ge        = trial >= {1'b0, den};
    assign trial_sub = trial - {1'b0, den};

    // Per-axis drag with sign, clamped to the signed 32-bit range.
    always_comb begin
        q = r_quo[31:0];
        if (r_ovf || q[31]) begin
            dv = r_neg[ax] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            dv = r_neg[ax] ? -$signed(q) : $signed(q);
        end
        diff = {r_vel[ax][63], r_vel[ax]} - {{33{dv[31]}}, dv};
        if (diff[64] != diff[63]) begin
            vel_sub = diff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            vel_sub = diff[63:0];
        end
    end

    assign cfg_ok = !i_cfg.mass[31] && (i_cfg.mass != 32'd0)
                    && !i_cfg.drag_area[31] && !i_cfg.heat_coefficient[31]
                    && !(i_cfg.heat_cap_enable
                         && (i_cfg.heat_limit[31] || (i_cfg.heat_limit == 32'd0)));
    assign dens_pos = !r_dens[31] && (r_dens != 32'd0);
    assign normal   = cfg_ok && dens_pos && (r_sum != 64'd0);

    assign o_stat.skip       = !cfg_ok || !dens_pos;
    assign o_stat.speed_zero = (r_sum == 64'd0);

    always_comb begin
        hsum = {r_heat[31], r_heat} + {1'b0, n_last_heat};
        hsat = (!hsum[32] && hsum[31]) ? 32'sh7FFF_FFFF : hsum[31:0];
        if (!cfg_ok) begin
            n_last_drag = r_last_drag;
            n_last_heat = r_last_heat;
            n_heat      = r_heat;
        end else if (!normal) begin
            n_last_drag = '0;
            n_last_heat = '0;
            n_heat      = r_heat;
        end else begin
            n_last_drag = (r_drag[63:31] != 33'd0) ? 32'sh7FFF_FFFF : r_drag[31:0];
            n_last_heat = (r_heat_rate[63:31] != 33'd0) ? 32'sh7FFF_FFFF
                                                        : r_heat_rate[31:0];
            n_heat      = (i_cfg.heat_cap_enable && (hsat > i_cfg.heat_limit))
                          ? i_cfg.heat_limit : hsat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat      <= '0;
            r_last_drag <= '0;
            r_last_heat <= '0;
        end else if (i_cmd.commit) begin
            r_heat      <= n_heat;
            r_last_drag <= n_last_drag;
            r_last_heat <= n_last_heat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            for (int k = 0; k < 3; k++) begin
                r_vel[k] <= in_vel[k];
                r_neg[k] <= in_vel[k][63];
                r_mag[k] <= in_vel[k][63] ? (48'd0 - ip[k]) : ip[k];
            end
            r_dens <= i_in_data.density;
            r_sum  <= '0;
        end else begin
            case (i_cmd.ph)
                PH_SQ0, PH_SQ1, PH_SQ2: begin
                    if (take) begin
                        r_sum <= sum_n[64] ? {64{1'b1}} : sum_n[63:0];
                    end
                end
                PH_SQRT: begin
                    if (i_cmd.cnt == 7'd0) begin
                        r_x    <= r_sum;
                        r_root <= '0;
                        r_bit  <= {2'b01, 62'd0};
                    end else begin
                        if (r_x >= rb) begin
                            r_x    <= r_x - rb;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                PH_V2:   if (take) r_v2 <= acc[63:0];
                PH_V3:   if (take) r_v3 <= acc_sat;
                PH_DRAG: if (take) r_drag <= acc_sat;
                PH_DHC:  if (take) r_hc <= acc[79:16];
                PH_HEAT: if (take) r_heat_rate <= acc_sat;
                PH_DIVM, PH_DV0, PH_DV1, PH_DV2: begin
                    if (i_cmd.cnt == 7'd0) begin
                        r_quo <= '0;
                        if (i_cmd.ph == PH_DIVM) begin
                            r_rem <= '0;
                            r_dvd <= acc[63:0];
                        end else begin
                            r_rem <= acc[63:32];
                            r_dvd <= {acc[31:0], 32'd0};
                            r_ovf <= (acc[127:64] != 64'd0) || (acc[63:32] >= r_root[31:0]);
                        end
                    end else if (i_cmd.cnt == ph_last(i_cmd.ph)) begin
                        if (i_cmd.ph == PH_DIVM) begin
                            r_dc <= r_quo;
                        end else begin
                            r_vel[ax] <= vel_sub;
                        end
                    end else begin
                        r_rem <= ge ? trial_sub[31:0] : trial[31:0];
                        r_dvd <= {r_dvd[62:0], 1'b0};
                        r_quo <= {r_quo[62:0], ge};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.new_vel_x    <= r_vel[0];
            r_out.new_vel_y    <= r_vel[1];
            r_out.new_vel_z    <= r_vel[2];
            r_out.drag_accel   <= n_last_drag;
            r_out.heating_rate <= n_last_heat;
            r_out.heat_total   <= n_heat;
            r_out.status       <= !cfg_ok;
        end
    end

    assign o_out_data = r_out;
endmodule

FILE: sv/adh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adh_ctrl
// Sequencer: walks the datapath through its phases and owns both handshakes.
// ----------------------------------------------------------------------------
module adh_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  adh_pkg::t_stat i_stat,
    output adh_pkg::t_cmd  o_cmd
);
    import adh_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_CHK, S_RUN, S_FIN} t_state;

    t_state     r_state, n_state;
    t_phase     r_ph, n_ph;
    logic [6:0] r_cnt, n_cnt;
    logic       r_ov, n_ov;
    logic       commit;
    logic       load_in;

    assign load_in = (r_state == S_IDLE) && i_in_valid;
    assign commit  = (r_state == S_FIN) && (!r_ov || i_out_ready);

    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_cnt   = r_cnt;
        n_ov    = commit || (r_ov && !i_out_ready);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHK;
            end
            S_CHK: begin
                n_ph  = PH_SQ0;
                n_cnt = '0;
                n_state = i_stat.skip ? S_FIN : S_RUN;
            end
            S_RUN: begin
                if (r_cnt == ph_last(r_ph)) begin
                    n_cnt = '0;
                    if (((r_ph == PH_SQRT) && i_stat.speed_zero) || (r_ph == PH_DV2)) begin
                        n_state = S_FIN;
                    end else begin
                        n_ph = t_phase'(r_ph + 5'd1);
                    end
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            S_FIN: begin
                if (commit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= PH_SQ0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_ov;
    assign o_cmd.load_in = load_in;
    assign o_cmd.commit  = commit;
    assign o_cmd.ph      = r_ph;
    assign o_cmd.cnt     = r_cnt;

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> (!r_ov || i_out_ready))
        else $error("result committed over an untaken beat");

    a_accept_to_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_in |=> (r_state == S_CHK))
        else $error("accepted beat did not start the check");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_cnt <= ph_last(r_ph)))
        else $error("phase counter ran past its end");

    a_commit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_ov)
        else $error("commit did not raise the output valid");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_ov && (r_state == S_IDLE)))
        else $error("reset left the block busy");
endmodule
